// ----- design/scd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Shared widths and payload types for the segment crossing depth unit.
// ----------------------------------------------------------------------------
package scd_pkg;

    // Default fraction width of the crossing parameters
    localparam int FRAC_BITS_DEF = 16;

    // Input coordinates and their differences
    localparam int COORD_W = 16;
    localparam int DELTA_W = COORD_W + 1;

    // Cross products, determinant and its magnitude
    localparam int PROD_W = 2 * DELTA_W;
    localparam int DET_W  = PROD_W + 1;
    localparam int MAG_W  = DET_W - 1;

    // Result points: Q16.8
    localparam int POINT_W  = 24;
    localparam int OUT_FRAC = 8;

    // Segment geometry carried down the pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] as_x;
        logic signed [COORD_W-1:0] as_y;
        logic signed [COORD_W-1:0] as_z;
        logic signed [COORD_W-1:0] bs_x;
        logic signed [COORD_W-1:0] bs_y;
        logic signed [COORD_W-1:0] bs_z;
        logic signed [DELTA_W-1:0] da_x;
        logic signed [DELTA_W-1:0] da_y;
        logic signed [DELTA_W-1:0] da_z;
        logic signed [DELTA_W-1:0] db_x;
        logic signed [DELTA_W-1:0] db_y;
        logic signed [DELTA_W-1:0] db_z;
    } geom_t;

    // Sideband that rides along the divider stages
    typedef struct packed {
        logic  hit;
        geom_t geom;
    } side_t;

endpackage
`default_nettype wire

// ----- design/scd_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_div_pipe
// Pipelined restoring divider for both crossing parameters. Each stage
// resolves one quotient bit of na * 2^FRAC_BITS / det and nb * 2^FRAC_BITS
// / det, with na, nb <= det, so the quotients fit in FRAC_BITS + 1 bits.
// ----------------------------------------------------------------------------
module scd_div_pipe #(
    parameter int FRAC_BITS = scd_pkg::FRAC_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    input  wire [scd_pkg::MAG_W-1:0]       det,
    input  wire [scd_pkg::MAG_W-1:0]       na,
    input  wire [scd_pkg::MAG_W-1:0]       nb,
    input  wire scd_pkg::side_t            in_side,
    output logic                           out_valid,
    output logic [FRAC_BITS:0]             ta,
    output logic [FRAC_BITS:0]             tb,
    output scd_pkg::side_t                 out_side
);

    localparam int QW    = FRAC_BITS + 1;
    localparam int MAG_W = scd_pkg::MAG_W;

    logic [MAG_W-1:0]     rem_a_reg [0:QW-1];
    logic [MAG_W-1:0]     rem_b_reg [0:QW-1];
    logic [QW-1:0]        q_a_reg   [0:QW-1];
    logic [QW-1:0]        q_b_reg   [0:QW-1];
    logic [MAG_W-1:0]     det_reg   [0:QW-1];
    scd_pkg::side_t       side_reg  [0:QW-1];
    logic [QW-1:0]        valid_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [MAG_W-1:0] ra_in;
        logic [MAG_W-1:0] rb_in;
        logic [MAG_W-1:0] d_in;
        logic [QW-1:0]    qa_in;
        logic [QW-1:0]    qb_in;
        scd_pkg::side_t   side_in;
        logic             valid_in;
        logic [MAG_W:0]   sa;
        logic [MAG_W:0]   sb;
        logic [MAG_W:0]   sa_sub;
        logic [MAG_W:0]   sb_sub;
        logic             bit_a;
        logic             bit_b;
        logic [MAG_W-1:0] rem_a_next;
        logic [MAG_W-1:0] rem_b_next;
        logic [QW-1:0]    q_a_next;
        logic [QW-1:0]    q_b_next;

        // Select stage inputs
        if (k == 0)
        begin : g_first
            assign ra_in    = na;
            assign rb_in    = nb;
            assign d_in     = det;
            assign qa_in    = '0;
            assign qb_in    = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
            // Top quotient bit: remainder is not doubled
            assign sa = {1'b0, ra_in};
            assign sb = {1'b0, rb_in};
        end
        else
        begin : g_next
            assign ra_in    = rem_a_reg[k-1];
            assign rb_in    = rem_b_reg[k-1];
            assign d_in     = det_reg[k-1];
            assign qa_in    = q_a_reg[k-1];
            assign qb_in    = q_b_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
            assign sa = {ra_in, 1'b0};
            assign sb = {rb_in, 1'b0};
        end

        // Compare and subtract for one quotient bit
        assign sa_sub = sa - {1'b0, d_in};
        assign sb_sub = sb - {1'b0, d_in};
        assign bit_a  = (sa >= {1'b0, d_in});
        assign bit_b  = (sb >= {1'b0, d_in});

        always_comb
        begin
            rem_a_next = bit_a ? sa_sub[MAG_W-1:0] : sa[MAG_W-1:0];
            rem_b_next = bit_b ? sb_sub[MAG_W-1:0] : sb[MAG_W-1:0];
            q_a_next = qa_in;
            q_b_next = qb_in;
            q_a_next[QW-1-k] = bit_a;
            q_b_next[QW-1-k] = bit_b;
        end

        // Advance the stage valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        // Hold the stage payload
        always_ff @(posedge clk)
        begin
            rem_a_reg[k] <= rem_a_next;
            rem_b_reg[k] <= rem_b_next;
            q_a_reg[k]   <= q_a_next;
            q_b_reg[k]   <= q_b_next;
            det_reg[k]   <= d_in;
            side_reg[k]  <= side_in;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign ta        = q_a_reg[QW-1];
    assign tb        = q_b_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

// ----- design/segment_crossing_depth_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_crossing_depth_unit
// Projected XY crossing test of two 3D segments with depth ordering.
// ----------------------------------------------------------------------------
// The unit takes one segment pair on every clock cycle: busy is always low,
// so any cycle with start high enters an item. Each result appears on the
// output ports for one cycle with done high, in input order. Results pass
// through the pipelined divider, which resolves one quotient bit per stage
// for FRAC_BITS + 1 stages, plus seven stages for the deltas, cross products,
// determinant, sign fix-up, point multiply, point add and output formatting.
// The receiver must take every result as it appears.
// ----------------------------------------------------------------------------
module segment_crossing_depth_unit #(
    parameter int FRAC_BITS = scd_pkg::FRAC_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire signed [scd_pkg::COORD_W-1:0]     a_start_x,
    input  wire signed [scd_pkg::COORD_W-1:0]     a_start_y,
    input  wire signed [scd_pkg::COORD_W-1:0]     a_start_z,
    input  wire signed [scd_pkg::COORD_W-1:0]     a_end_x,
    input  wire signed [scd_pkg::COORD_W-1:0]     a_end_y,
    input  wire signed [scd_pkg::COORD_W-1:0]     a_end_z,
    input  wire signed [scd_pkg::COORD_W-1:0]     b_start_x,
    input  wire signed [scd_pkg::COORD_W-1:0]     b_start_y,
    input  wire signed [scd_pkg::COORD_W-1:0]     b_start_z,
    input  wire signed [scd_pkg::COORD_W-1:0]     b_end_x,
    input  wire signed [scd_pkg::COORD_W-1:0]     b_end_y,
    input  wire signed [scd_pkg::COORD_W-1:0]     b_end_z,
    output logic                                  done,
    output logic                                  crosses,
    output logic                                  a_is_behind,
    output logic                                  b_is_behind,
    output logic signed [scd_pkg::POINT_W-1:0]    a_point_x,
    output logic signed [scd_pkg::POINT_W-1:0]    a_point_y,
    output logic signed [scd_pkg::POINT_W-1:0]    a_point_z,
    output logic signed [scd_pkg::POINT_W-1:0]    b_point_x,
    output logic signed [scd_pkg::POINT_W-1:0]    b_point_y,
    output logic signed [scd_pkg::POINT_W-1:0]    b_point_z
);

    localparam int COORD_W = scd_pkg::COORD_W;
    localparam int DELTA_W = scd_pkg::DELTA_W;
    localparam int PROD_W  = scd_pkg::PROD_W;
    localparam int DET_W   = scd_pkg::DET_W;
    localparam int MAG_W   = scd_pkg::MAG_W;
    localparam int POINT_W = scd_pkg::POINT_W;
    localparam int QW      = FRAC_BITS + 1;
    localparam int PW      = DELTA_W + QW + 1;
    localparam int SHIFT   = FRAC_BITS - scd_pkg::OUT_FRAC;
    localparam int EXT_W   = PW - COORD_W - FRAC_BITS;
    localparam int LATENCY = QW + 7;

    // Stage 1: deltas and relative start
    logic                      v1_reg;
    scd_pkg::geom_t            geom1_reg;
    scd_pkg::geom_t            geom1_next;
    logic signed [DELTA_W-1:0] rx1_reg;
    logic signed [DELTA_W-1:0] ry1_reg;

    // Stage 2: cross products
    logic                      v2_reg;
    scd_pkg::geom_t            geom2_reg;
    logic signed [PROD_W-1:0]  p_det_l_reg;
    logic signed [PROD_W-1:0]  p_det_r_reg;
    logic signed [PROD_W-1:0]  p_na_l_reg;
    logic signed [PROD_W-1:0]  p_na_r_reg;
    logic signed [PROD_W-1:0]  p_nb_l_reg;
    logic signed [PROD_W-1:0]  p_nb_r_reg;

    // Stage 3: determinant and numerators
    logic                      v3_reg;
    scd_pkg::geom_t            geom3_reg;
    logic signed [DET_W-1:0]   det3_reg;
    logic signed [DET_W-1:0]   na3_reg;
    logic signed [DET_W-1:0]   nb3_reg;

    // Stage 4: sign fix-up and span test
    logic                      v4_reg;
    scd_pkg::side_t            side4_reg;
    logic [MAG_W-1:0]          det4_reg;
    logic [MAG_W-1:0]          na4_reg;
    logic [MAG_W-1:0]          nb4_reg;
    logic signed [DET_W-1:0]   det_abs;
    logic signed [DET_W-1:0]   na_fix;
    logic signed [DET_W-1:0]   nb_fix;
    logic                      hit_next;

    // Divider outputs
    logic                      vd;
    logic [QW-1:0]             ta_d;
    logic [QW-1:0]             tb_d;
    scd_pkg::side_t            side_d;

    // Stage 5: delta times parameter
    logic                      v5_reg;
    scd_pkg::side_t            side5_reg;
    logic signed [PW-1:0]      m_ax_reg;
    logic signed [PW-1:0]      m_ay_reg;
    logic signed [PW-1:0]      m_az_reg;
    logic signed [PW-1:0]      m_bx_reg;
    logic signed [PW-1:0]      m_by_reg;
    logic signed [PW-1:0]      m_bz_reg;
    logic signed [QW:0]        ta_s;
    logic signed [QW:0]        tb_s;

    // Stage 6: full precision points
    logic                      v6_reg;
    logic                      hit6_reg;
    logic signed [PW-1:0]      pax_reg;
    logic signed [PW-1:0]      pay_reg;
    logic signed [PW-1:0]      paz_reg;
    logic signed [PW-1:0]      pbx_reg;
    logic signed [PW-1:0]      pby_reg;
    logic signed [PW-1:0]      pbz_reg;

    // Stage 7: output registers
    logic                      done_reg;
    logic                      crosses_reg;
    logic                      a_behind_reg;
    logic                      b_behind_reg;
    logic signed [POINT_W-1:0] a_point_x_reg;
    logic signed [POINT_W-1:0] a_point_y_reg;
    logic signed [POINT_W-1:0] a_point_z_reg;
    logic signed [POINT_W-1:0] b_point_x_reg;
    logic signed [POINT_W-1:0] b_point_y_reg;
    logic signed [POINT_W-1:0] b_point_z_reg;

    // Every cycle takes an item
    assign busy = 1'b0;

    // ---- Stage 1 ----
    always_comb
    begin
        geom1_next.as_x = a_start_x;
        geom1_next.as_y = a_start_y;
        geom1_next.as_z = a_start_z;
        geom1_next.bs_x = b_start_x;
        geom1_next.bs_y = b_start_y;
        geom1_next.bs_z = b_start_z;
        geom1_next.da_x = DELTA_W'(a_end_x) - DELTA_W'(a_start_x);
        geom1_next.da_y = DELTA_W'(a_end_y) - DELTA_W'(a_start_y);
        geom1_next.da_z = DELTA_W'(a_end_z) - DELTA_W'(a_start_z);
        geom1_next.db_x = DELTA_W'(b_end_x) - DELTA_W'(b_start_x);
        geom1_next.db_y = DELTA_W'(b_end_y) - DELTA_W'(b_start_y);
        geom1_next.db_z = DELTA_W'(b_end_z) - DELTA_W'(b_start_z);
    end

    always_ff @(posedge clk)
    begin
        geom1_reg <= geom1_next;
        rx1_reg   <= DELTA_W'(b_start_x) - DELTA_W'(a_start_x);
        ry1_reg   <= DELTA_W'(b_start_y) - DELTA_W'(a_start_y);
    end

    // ---- Stage 2: six products ----
    always_ff @(posedge clk)
    begin
        geom2_reg   <= geom1_reg;
        p_det_l_reg <= PROD_W'(geom1_reg.db_x) * PROD_W'(geom1_reg.da_y);
        p_det_r_reg <= PROD_W'(geom1_reg.da_x) * PROD_W'(geom1_reg.db_y);
        p_na_l_reg  <= PROD_W'(geom1_reg.db_x) * PROD_W'(ry1_reg);
        p_na_r_reg  <= PROD_W'(geom1_reg.db_y) * PROD_W'(rx1_reg);
        p_nb_l_reg  <= PROD_W'(geom1_reg.da_x) * PROD_W'(ry1_reg);
        p_nb_r_reg  <= PROD_W'(geom1_reg.da_y) * PROD_W'(rx1_reg);
    end

    // ---- Stage 3: differences ----
    always_ff @(posedge clk)
    begin
        geom3_reg <= geom2_reg;
        det3_reg  <= DET_W'(p_det_l_reg) - DET_W'(p_det_r_reg);
        na3_reg   <= DET_W'(p_na_l_reg) - DET_W'(p_na_r_reg);
        nb3_reg   <= DET_W'(p_nb_l_reg) - DET_W'(p_nb_r_reg);
    end

    // ---- Stage 4: make det positive, test both spans ----
    always_comb
    begin
        det_abs  = det3_reg[DET_W-1] ? -det3_reg : det3_reg;
        na_fix   = det3_reg[DET_W-1] ? -na3_reg  : na3_reg;
        nb_fix   = det3_reg[DET_W-1] ? -nb3_reg  : nb3_reg;
        hit_next = (det_abs != '0) && !na_fix[DET_W-1] && !nb_fix[DET_W-1]
                   && (na_fix <= det_abs) && (nb_fix <= det_abs);
    end

    always_ff @(posedge clk)
    begin
        side4_reg.hit  <= hit_next;
        side4_reg.geom <= geom3_reg;
        det4_reg       <= det_abs[MAG_W-1:0];
        na4_reg        <= na_fix[MAG_W-1:0];
        nb4_reg        <= nb_fix[MAG_W-1:0];
    end

    // ---- Divider ----
    scd_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .det       (det4_reg),
        .na        (na4_reg),
        .nb        (nb4_reg),
        .in_side   (side4_reg),
        .out_valid (vd),
        .ta        (ta_d),
        .tb        (tb_d),
        .out_side  (side_d)
    );

    // ---- Stage 5: scale deltas by the parameters ----
    assign ta_s = $signed({1'b0, ta_d});
    assign tb_s = $signed({1'b0, tb_d});

    always_ff @(posedge clk)
    begin
        side5_reg <= side_d;
        m_ax_reg  <= PW'(side_d.geom.da_x) * PW'(ta_s);
        m_ay_reg  <= PW'(side_d.geom.da_y) * PW'(ta_s);
        m_az_reg  <= PW'(side_d.geom.da_z) * PW'(ta_s);
        m_bx_reg  <= PW'(side_d.geom.db_x) * PW'(tb_s);
        m_by_reg  <= PW'(side_d.geom.db_y) * PW'(tb_s);
        m_bz_reg  <= PW'(side_d.geom.db_z) * PW'(tb_s);
    end

    // ---- Stage 6: add the scaled start points ----
    always_ff @(posedge clk)
    begin
        hit6_reg <= side5_reg.hit;
        pax_reg  <= {{EXT_W{side5_reg.geom.as_x[COORD_W-1]}}, side5_reg.geom.as_x,
                     {FRAC_BITS{1'b0}}} + m_ax_reg;
        pay_reg  <= {{EXT_W{side5_reg.geom.as_y[COORD_W-1]}}, side5_reg.geom.as_y,
                     {FRAC_BITS{1'b0}}} + m_ay_reg;
        paz_reg  <= {{EXT_W{side5_reg.geom.as_z[COORD_W-1]}}, side5_reg.geom.as_z,
                     {FRAC_BITS{1'b0}}} + m_az_reg;
        pbx_reg  <= {{EXT_W{side5_reg.geom.bs_x[COORD_W-1]}}, side5_reg.geom.bs_x,
                     {FRAC_BITS{1'b0}}} + m_bx_reg;
        pby_reg  <= {{EXT_W{side5_reg.geom.bs_y[COORD_W-1]}}, side5_reg.geom.bs_y,
                     {FRAC_BITS{1'b0}}} + m_by_reg;
        pbz_reg  <= {{EXT_W{side5_reg.geom.bs_z[COORD_W-1]}}, side5_reg.geom.bs_z,
                     {FRAC_BITS{1'b0}}} + m_bz_reg;
    end

    // ---- Stage 7: depth order, floor to Q16.8, zero on miss ----
    always_ff @(posedge clk)
    begin
        crosses_reg   <= hit6_reg;
        a_behind_reg  <= hit6_reg && (paz_reg <= pbz_reg);
        b_behind_reg  <= hit6_reg && (pbz_reg <= paz_reg);
        a_point_x_reg <= hit6_reg ? pax_reg[SHIFT +: POINT_W] : '0;
        a_point_y_reg <= hit6_reg ? pay_reg[SHIFT +: POINT_W] : '0;
        a_point_z_reg <= hit6_reg ? paz_reg[SHIFT +: POINT_W] : '0;
        b_point_x_reg <= hit6_reg ? pbx_reg[SHIFT +: POINT_W] : '0;
        b_point_y_reg <= hit6_reg ? pby_reg[SHIFT +: POINT_W] : '0;
        b_point_z_reg <= hit6_reg ? pbz_reg[SHIFT +: POINT_W] : '0;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= vd;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    assign done        = done_reg;
    assign crosses     = crosses_reg;
    assign a_is_behind = a_behind_reg;
    assign b_is_behind = b_behind_reg;
    assign a_point_x   = a_point_x_reg;
    assign a_point_y   = a_point_y_reg;
    assign a_point_z   = a_point_z_reg;
    assign b_point_x   = b_point_x_reg;
    assign b_point_y   = b_point_y_reg;
    assign b_point_z   = b_point_z_reg;

    // Every accepted item leaves the pipeline with a done strobe
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after fixed latency");

    // A crossing always flags at least one segment as behind
    a_behind_on_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (done && crosses) |-> (a_is_behind || b_is_behind))
        else $error("crossing without depth order");

    // A miss carries no depth flags
    a_no_flags_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !crosses) |-> (!a_is_behind && !b_is_behind))
        else $error("depth flag set without crossing");

    // A miss carries zero points
    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !crosses) |-> (a_point_x == '0 && a_point_y == '0 && a_point_z == '0
                                && b_point_x == '0 && b_point_y == '0
                                && b_point_z == '0))
        else $error("nonzero point without crossing");

endmodule
`default_nettype wire

// ----- tb/segment_crossing_depth_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_crossing_depth_unit_test
// Self-checking bench for the projected segment crossing and depth unit.
// Segment pairs are driven through the start handshake with random gaps. An
// in-bench integer model predicts the crossing flag, depth order and Q16.8
// points of every item, and each done strobe is compared field by field.
// ----------------------------------------------------------------------------
module segment_crossing_depth_unit_test;

    localparam int COORD_W     = scd_pkg::COORD_W;
    localparam int POINT_W     = scd_pkg::POINT_W;
    localparam int FRAC_BITS   = scd_pkg::FRAC_BITS_DEF;
    localparam int SHIFT       = FRAC_BITS - scd_pkg::OUT_FRAC;
    localparam int LATENCY     = FRAC_BITS + 8;
    localparam int CYCLE_LIMIT = 200000;

    // One segment pair as driven on the ports
    typedef struct packed {
        logic signed [COORD_W-1:0] as_x;
        logic signed [COORD_W-1:0] as_y;
        logic signed [COORD_W-1:0] as_z;
        logic signed [COORD_W-1:0] ae_x;
        logic signed [COORD_W-1:0] ae_y;
        logic signed [COORD_W-1:0] ae_z;
        logic signed [COORD_W-1:0] bs_x;
        logic signed [COORD_W-1:0] bs_y;
        logic signed [COORD_W-1:0] bs_z;
        logic signed [COORD_W-1:0] be_x;
        logic signed [COORD_W-1:0] be_y;
        logic signed [COORD_W-1:0] be_z;
    } seg_pair_t;

    // One crossing result
    typedef struct packed {
        logic                      crosses;
        logic                      a_behind;
        logic                      b_behind;
        logic signed [POINT_W-1:0] a_x;
        logic signed [POINT_W-1:0] a_y;
        logic signed [POINT_W-1:0] a_z;
        logic signed [POINT_W-1:0] b_x;
        logic signed [POINT_W-1:0] b_y;
        logic signed [POINT_W-1:0] b_z;
    } crossing_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    seg_pair_t pair_in;

    wire                      busy;
    wire                      done;
    wire                      crosses;
    wire                      a_is_behind;
    wire                      b_is_behind;
    wire signed [POINT_W-1:0] a_point_x;
    wire signed [POINT_W-1:0] a_point_y;
    wire signed [POINT_W-1:0] a_point_z;
    wire signed [POINT_W-1:0] b_point_x;
    wire signed [POINT_W-1:0] b_point_y;
    wire signed [POINT_W-1:0] b_point_z;

    crossing_t expected_crossings[$];
    int        mismatch_count;
    int        cycle_count;
    bit        no_gaps;

    segment_crossing_depth_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .a_start_x  (pair_in.as_x),
        .a_start_y  (pair_in.as_y),
        .a_start_z  (pair_in.as_z),
        .a_end_x    (pair_in.ae_x),
        .a_end_y    (pair_in.ae_y),
        .a_end_z    (pair_in.ae_z),
        .b_start_x  (pair_in.bs_x),
        .b_start_y  (pair_in.bs_y),
        .b_start_z  (pair_in.bs_z),
        .b_end_x    (pair_in.be_x),
        .b_end_y    (pair_in.be_y),
        .b_end_z    (pair_in.be_z),
        .done       (done),
        .crosses    (crosses),
        .a_is_behind(a_is_behind),
        .b_is_behind(b_is_behind),
        .a_point_x  (a_point_x),
        .a_point_y  (a_point_y),
        .a_point_z  (a_point_z),
        .b_point_x  (b_point_x),
        .b_point_y  (b_point_y),
        .b_point_z  (b_point_z)
    );

    // Toggle the clock every half period
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Exact integer crossing solve with Q16.8 floored points
    function automatic crossing_t predict_crossing(input seg_pair_t p);
        longint    dax, day, daz, dbx, dby, dbz, ox, oy;
        longint    det, na, nb, ta, tb;
        longint    pax, pay, paz, pbx, pby, pbz;
        crossing_t r;
        r   = '0;
        dax = longint'(p.ae_x) - longint'(p.as_x);
        day = longint'(p.ae_y) - longint'(p.as_y);
        daz = longint'(p.ae_z) - longint'(p.as_z);
        dbx = longint'(p.be_x) - longint'(p.bs_x);
        dby = longint'(p.be_y) - longint'(p.bs_y);
        dbz = longint'(p.be_z) - longint'(p.bs_z);
        ox  = longint'(p.bs_x) - longint'(p.as_x);
        oy  = longint'(p.bs_y) - longint'(p.as_y);
        det = dbx * day - dax * dby;
        na  = dbx * oy - dby * ox;
        nb  = dax * oy - day * ox;
        // Normalize the sign so the span test works against a positive det
        if (det < 0)
        begin
            det = -det;
            na  = -na;
            nb  = -nb;
        end
        if (det == 0 || na < 0 || na > det || nb < 0 || nb > det)
            return r;
        ta  = (na <<< FRAC_BITS) / det;
        tb  = (nb <<< FRAC_BITS) / det;
        pax = (longint'(p.as_x) <<< FRAC_BITS) + dax * ta;
        pay = (longint'(p.as_y) <<< FRAC_BITS) + day * ta;
        paz = (longint'(p.as_z) <<< FRAC_BITS) + daz * ta;
        pbx = (longint'(p.bs_x) <<< FRAC_BITS) + dbx * tb;
        pby = (longint'(p.bs_y) <<< FRAC_BITS) + dby * tb;
        pbz = (longint'(p.bs_z) <<< FRAC_BITS) + dbz * tb;
        r.crosses  = 1'b1;
        r.a_behind = (paz <= pbz);
        r.b_behind = (pbz <= paz);
        // Arithmetic shift floors toward minus infinity; keep the low 24 bits
        r.a_x = POINT_W'(pax >>> SHIFT);
        r.a_y = POINT_W'(pay >>> SHIFT);
        r.a_z = POINT_W'(paz >>> SHIFT);
        r.b_x = POINT_W'(pbx >>> SHIFT);
        r.b_y = POINT_W'(pby >>> SHIFT);
        r.b_z = POINT_W'(pbz >>> SHIFT);
        return r;
    endfunction

    function automatic int rnd_range(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic seg_pair_t make_pair(
        input int asx, input int asy, input int asz,
        input int aex, input int aey, input int aez,
        input int bsx, input int bsy, input int bsz,
        input int bex, input int bey, input int bez);
        seg_pair_t p;
        p.as_x = COORD_W'(asx);
        p.as_y = COORD_W'(asy);
        p.as_z = COORD_W'(asz);
        p.ae_x = COORD_W'(aex);
        p.ae_y = COORD_W'(aey);
        p.ae_z = COORD_W'(aez);
        p.bs_x = COORD_W'(bsx);
        p.bs_y = COORD_W'(bsy);
        p.bs_z = COORD_W'(bsz);
        p.be_x = COORD_W'(bex);
        p.be_y = COORD_W'(bey);
        p.be_z = COORD_W'(bez);
        return p;
    endfunction

    // Send one item, with an occasional random gap in front of it
    task automatic send_pair(input seg_pair_t p);
        int gap;
        if (!no_gaps && $urandom_range(99) < 15)
        begin
            gap = ($urandom_range(4) == 0) ? rnd_range(1, LATENCY + 6) : rnd_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start   <= 1'b1;
        pair_in <= p;
        // Hold the item until the unit takes it
        do
            @(posedge clk);
        while (busy);
        expected_crossings.insert(expected_crossings.size(), predict_crossing(p));
    endtask

    // Drop start and hold off until every pending result has come back
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_crossings.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        // Plain X crossing, B lower in depth, then A lower, then a tie
        send_pair(make_pair(-100, 0, 5, 100, 0, 5, 0, -100, 3, 0, 100, 3));
        send_pair(make_pair(-100, 0, 3, 100, 0, 3, 0, -100, 5, 0, 100, 5));
        send_pair(make_pair(-100, 0, 4, 100, 0, 4, 0, -100, 4, 0, 100, 4));
        // Positive determinant: B runs the other way
        send_pair(make_pair(-100, 0, 5, 100, 0, 5, 0, 100, 3, 0, -100, 3));
        // Parallel, collinear overlap and a zero-length segment
        send_pair(make_pair(0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 5, 0));
        send_pair(make_pair(0, 0, 0, 10, 0, 0, 5, 0, 0, 15, 0, 0));
        send_pair(make_pair(5, 0, 1, 5, 0, 1, 0, 0, 0, 10, 0, 0));
        // Touching endpoints, end on end and a T junction
        send_pair(make_pair(0, 0, 1, 10, 10, 2, 10, 10, 2, 20, 0, 7));
        send_pair(make_pair(0, 0, -3, 10, 10, 9, 20, 0, 4, 10, 10, 9));
        send_pair(make_pair(0, -5, 2, 0, 0, 2, -8, 0, 6, 8, 0, -6));
        // Narrow miss just past the end of A
        send_pair(make_pair(0, 0, 0, 10, 0, 0, 11, -5, 0, 11, 5, 0));
        // Fractional crossings with negative floored points
        send_pair(make_pair(0, 0, 0, 3, 1, 7, 0, 1, -5, 3, 0, 9));
        send_pair(make_pair(-7, -3, -1, 2, 5, -9, -6, 4, 3, 1, -6, -2));
        // Full-range diagonals with extreme depths
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                            -32768, 32767, 32767, 32767, -32768, -32768));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, -32768,
                            -32768, 32767, -32768, 32767, -32768, 32767));
        send_pair(make_pair(-32768, 0, -32768, 32767, 0, -32768,
                            0, -32768, 32767, 0, 32767, 32767));
        send_pair(make_pair(32767, 0, 32767, -32768, 0, 32767,
                            0, 32767, -32768, 0, -32768, -32768));
        // All-minimum and all-maximum fields
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767, 32767, 32767));
        // Corner to corner sharing the far endpoint
        send_pair(make_pair(-32768, -32768, 0, 32767, 32767, -1,
                            32767, -32768, 0, 32767, 32767, -1));
    endtask

    // Pairs built around a common center so most of them cross
    task automatic test_crossing_stream(input int count);
        seg_pair_t p;
        int        cx, cy, dxa, dya, dxb, dyb, k1, k2, k3, k4, zt;
        for (int n = 0; n < count; n++)
        begin
            cx  = rnd_range(-15000, 15000);
            cy  = rnd_range(-15000, 15000);
            dxa = rnd_range(-1000, 1000);
            dya = rnd_range(-1000, 1000);
            dxb = rnd_range(-1000, 1000);
            dyb = rnd_range(-1000, 1000);
            k1  = rnd_range(0, 16);
            k2  = rnd_range(0, 16);
            k3  = rnd_range(0, 16);
            k4  = rnd_range(0, 16);
            p = make_pair(cx - dxa * k1, cy - dya * k1, rnd_range(-32768, 32767),
                          cx + dxa * k2, cy + dya * k2, rnd_range(-32768, 32767),
                          cx - dxb * k3, cy - dyb * k3, rnd_range(-32768, 32767),
                          cx + dxb * k4, cy + dyb * k4, rnd_range(-32768, 32767));
            // Flat segments at one shared depth force a tie
            if ($urandom_range(7) == 0)
            begin
                zt     = rnd_range(-32768, 32767);
                p.as_z = COORD_W'(zt);
                p.ae_z = COORD_W'(zt);
                p.bs_z = COORD_W'(zt);
                p.be_z = COORD_W'(zt);
            end
            // Run one long stretch back to back, and drain once mid-stream
            no_gaps = (n >= count / 4 && n < count / 2);
            if (n == count / 2)
                wait_drained();
            send_pair(p);
        end
        no_gaps = 1'b0;
    endtask

    // Tiny coordinates: parallel, touching and tied cases come up often
    task automatic test_small_grid(input int count);
        for (int n = 0; n < count; n++)
            send_pair(make_pair(rnd_range(-4, 4), rnd_range(-4, 4), rnd_range(-3, 3),
                                rnd_range(-4, 4), rnd_range(-4, 4), rnd_range(-3, 3),
                                rnd_range(-4, 4), rnd_range(-4, 4), rnd_range(-3, 3),
                                rnd_range(-4, 4), rnd_range(-4, 4), rnd_range(-3, 3)));
    endtask

    // Raw patterns over the whole field range, biased toward the extremes
    task automatic test_full_range(input int count);
        logic [12*COORD_W-1:0] raw;
        for (int n = 0; n < count; n++)
        begin
            for (int f = 0; f < 12; f++)
            begin
                case ($urandom_range(7))
                    0:       raw[f*COORD_W +: COORD_W] = 16'h8000;
                    1:       raw[f*COORD_W +: COORD_W] = 16'h7fff;
                    default: raw[f*COORD_W +: COORD_W] = COORD_W'($urandom);
                endcase
            end
            send_pair(seg_pair_t'(raw));
        end
    endtask

    task automatic check_field(input string name, input logic signed [POINT_W-1:0] want,
                               input logic signed [POINT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d (0x%h) actual %0d (0x%h)",
                     $time, name, want, want, got, got);
            mismatch_count++;
        end
    endtask

    // Compare every strobed result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        crossing_t want;
        if (rst_n && done)
        begin
            if (expected_crossings.size() == 0)
            begin
                $display("%0t: result with no item pending, expected none actual crosses=%0b",
                         $time, crosses);
                mismatch_count++;
            end
            else
            begin
                want = expected_crossings.pop_front();
                check_field("crosses",     POINT_W'(want.crosses),  POINT_W'(crosses));
                check_field("a_is_behind", POINT_W'(want.a_behind), POINT_W'(a_is_behind));
                check_field("b_is_behind", POINT_W'(want.b_behind), POINT_W'(b_is_behind));
                check_field("a_point_x",   want.a_x, a_point_x);
                check_field("a_point_y",   want.a_y, a_point_y);
                check_field("a_point_z",   want.a_z, a_point_z);
                check_field("b_point_x",   want.b_x, b_point_x);
                check_field("b_point_y",   want.b_y, b_point_y);
                check_field("b_point_z",   want.b_z, b_point_z);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        no_gaps        = 1'b0;
        start          = 1'b0;
        pair_in        = '0;
        rst_n          = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_crossing_stream(1000);
        test_small_grid(400);
        test_full_range(350);

        // Let the pipeline empty, then settle a little longer
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
